// File: hw/rtl/rcd_pkg.sv
// ---------------------------------------------------------------------------
// rcd_pkg
// Shared types, constants and helpers of the random CV, clock and delay block.
// ---------------------------------------------------------------------------
package rcd_pkg;

	// delay store geometry
	localparam int DELAY_DEPTH = 32768;
	localparam int DLY_AW      = $clog2(DELAY_DEPTH);
	localparam int DLY_PW      = DLY_AW + 13;

	localparam logic [7:0] GATE_TICKS = 8'd200;
	localparam logic [2:0] DECIMATE   = 3'd4;

	// LCG
	localparam logic [31:0] LCG_MUL   = 32'd1664525;
	localparam logic [31:0] LCG_INC   = 32'd1013904223;
	localparam logic [31:0] LCG_INIT  = 32'd1;
	localparam logic [31:0] LCG_FIRST = LCG_INIT * LCG_MUL + LCG_INC;

	localparam int          GAIN_DIV   = 4095;
	localparam logic [11:0] KNOB_MAX   = 12'd4095;
	localparam logic [15:0] GAIN_HALF  = 16'd16384;
	localparam logic [15:0] GAIN_UNITY = 16'd32768;
	localparam logic [14:0] CLK_SPAN   = 15'd24000;
	localparam logic [16:0] CLK_BASE   = 17'd50;
	localparam logic [9:0]  SMOOTH_NEW = 10'd819;
	localparam logic [14:0] SMOOTH_OLD = 15'd31949;

	typedef struct packed {
		logic        [11:0] knob_main;
		logic        [11:0] knob_x;
		logic        [11:0] knob_y;
		logic signed [11:0] cv_in_a;
		logic signed [11:0] cv_in_b;
		logic               cv_a_plugged;
		logic               cv_b_plugged;
		logic               trig_plugged;
		logic               trig_rise;
		logic signed [11:0] audio_in_l;
		logic signed [11:0] audio_in_r;
	} in_word_t;

	typedef struct packed {
		logic signed [11:0] mix_cv;
		logic signed [11:0] held_cv;
		logic               gate_a;
		logic               gate_b;
		logic signed [11:0] audio_out_l;
		logic signed [11:0] audio_out_r;
		logic               audio_update;
	} out_word_t;

	// sequencer to delay unit
	typedef struct packed {
		logic mul_en;
		logic upd_en;
		logic fresh;
		logic commit;
	} dly_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_MIX  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// Q15 gain (knob << 15) / 4095, saturated. 32768 = 8*4095 + 8, so the
	// quotient is 8*knob plus floor(8*knob / 4095), which is at most 8.
	function automatic logic [14:0] q15_gain(input logic [11:0] knob);
		logic [14:0] base;
		logic [3:0]  q;
		logic [15:0] sum;
		base = {knob, 3'b000};
		q    = '0;
		for (int j = 1; j <= 8; j++) begin
			if (32'(base) >= 32'(j * GAIN_DIV))
				q = q + 4'd1;
		end
		sum = {1'b0, base} + {12'b0, q};
		return sum[15] ? 15'h7fff : sum[14:0];
	endfunction

endpackage

// File: hw/rtl/rcd_ram.sv
// ---------------------------------------------------------------------------
// rcd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rcd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/rcd_delay.sv
// ---------------------------------------------------------------------------
// rcd_delay
// Stereo delay store: knob smoothing, write pointer, RAM access and held
// output samples. Entries not yet written read as zero.
// ---------------------------------------------------------------------------
module rcd_delay (
	input  logic               clk,
	input  logic               arst_n,
	input  rcd_pkg::dly_ctl_t  ctl,
	input  logic [11:0]        knob_main,
	input  logic signed [11:0] audio_l,
	input  logic signed [11:0] audio_r,
	output logic signed [11:0] held_l,
	output logic signed [11:0] held_r
);
	import rcd_pkg::*;

	logic [21:0]        pk_s2;
	logic [26:0]        ps_s2;
	logic [11:0]        sm_q;
	logic [DLY_AW-1:0]  wp_q;
	logic               wrap_q;
	logic               fwd_s3;
	logic               vld_s3;
	logic [11:0]        held_l_q;
	logic [11:0]        held_r_q;

	logic [27:0]        sm_sum;
	logic [11:0]        sm_new;
	logic [DLY_PW-1:0]  dprod;
	logic [DLY_AW-1:0]  delay;
	logic               wp_ge;
	logic [DLY_AW:0]    rd_wrap;
	logic [DLY_AW-1:0]  rd;
	logic               wp_last;
	logic [23:0]        rd_data;
	logic [23:0]        sel;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			pk_s2 <= 22'(knob_main) * 22'(SMOOTH_NEW);
			ps_s2 <= 27'(sm_q) * 27'(SMOOTH_OLD);
		end
	end

	always_comb begin
		sm_sum  = {6'b0, pk_s2} + {1'b0, ps_s2};
		sm_new  = sm_sum[26:15];
		dprod   = DLY_PW'(sm_new) * DLY_PW'(DELAY_DEPTH);
		delay   = dprod[12 +: DLY_AW];
		wp_ge   = wp_q >= delay;
		rd_wrap = ({1'b0, wp_q} + (DLY_AW+1)'(DELAY_DEPTH)) - {1'b0, delay};
		rd      = wp_ge ? (wp_q - delay) : rd_wrap[DLY_AW-1:0];
		wp_last = wp_q == DLY_AW'(DELAY_DEPTH - 1);
	end

	rcd_ram #(
		.WIDTH(24),
		.DEPTH(DELAY_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctl.upd_en),
		.waddr (wp_q),
		.wdata ({audio_l, audio_r}),
		.re    (ctl.upd_en),
		.raddr (rd),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_q   <= '0;
			wp_q   <= '0;
			wrap_q <= 1'b0;
			fwd_s3 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ctl.upd_en) begin
			sm_q   <= sm_new;
			wp_q   <= wp_last ? '0 : wp_q + DLY_AW'(1);
			wrap_q <= wrap_q | wp_last;
			// a zero delay reads the word written in the same cycle
			fwd_s3 <= delay == '0;
			vld_s3 <= wrap_q | wp_ge;
		end
	end

	// audio inputs stay on the input register until the word is finished
	assign sel = fwd_s3 ? {audio_l, audio_r} : (vld_s3 ? rd_data : 24'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_l_q <= '0;
			held_r_q <= '0;
		end else if (ctl.commit) begin
			held_l_q <= sel[23:12];
			held_r_q <= sel[11:0];
		end
	end

	assign held_l = ctl.fresh ? sel[23:12] : held_l_q;
	assign held_r = ctl.fresh ? sel[11:0]  : held_r_q;

endmodule

// File: hw/rtl/random_cv_clock_and_delay.sv
// ---------------------------------------------------------------------------
// random_cv_clock_and_delay
// Random CV mixer, knob-set clock divider with two gates, and stereo delay.
// ---------------------------------------------------------------------------
// Usage:
//   One input word per sample tick on in_word (valid/ready), one output word
//   per input word on out_word (valid/ready).
//   Each word walks a four-state sequencer: accept, multiply (gains, LCG,
//   clock period, knob smoothing), mix and delay store access, finish.
//   in_ready is high only while the sequencer is idle, so a word passes
//   the multiply, mix and finish states before its output is registered,
//   and no new word is accepted meanwhile; the single delay RAM read/write
//   slot and the chained multiplies are the reason for this.
//   The output register decouples the receiver: a finished word waits there
//   while the next one is accepted and processed. If the receiver still
//   stalls when the next word is finished, the sequencer holds in its last
//   state and no state is committed until the output register frees.
//   Reset (arst_n low) returns the control, timer and held state to its
//   initial values. The delay store needs no clearing pass: until the
//   write pointer first wraps, reads behind it return zero.
// ---------------------------------------------------------------------------
module random_cv_clock_and_delay (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rcd_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output rcd_pkg::out_word_t out_word
);
	import rcd_pkg::*;

	state_t    state_q, state_d;
	in_word_t  in_q;
	out_word_t out_q, out_d;
	logic      out_valid_q;
	logic      accept;
	logic      fire;

	logic [31:0]        lcg_q;
	logic [2:0]         dec_q;
	logic [2:0]         dec_m;
	logic               upd_s2;
	logic [10:0]        r_s2;
	logic [14:0]        gx;
	logic [14:0]        gy;
	logic [12:0]        src1;
	logic signed [28:0] p1_s2;
	logic signed [27:0] p2_s2;
	logic [30:0]        pp_s2;
	logic [14:0]        gy_s2;

	logic signed [12:0] s1;
	logic signed [12:0] s2;
	logic signed [15:0] gy_off;
	logic signed [25:0] m1;
	logic signed [25:0] m2;
	logic signed [26:0] msum_s3;
	logic [16:0]        period;
	logic [15:0]        cnt_next;
	logic               pulse;
	logic               pulse_s3;
	logic [15:0]        clk_cnt_q;

	logic signed [11:0] mix;
	logic               beat;
	logic               a_lvl, b_lvl;
	logic [7:0]         a_tmr, b_tmr;
	logic [11:0]        hold;
	logic               gate_a_q, gate_b_q;
	logic [7:0]         gate_a_tmr_q, gate_b_tmr_q;
	logic [11:0]        hold_q;

	dly_ctl_t           dctl;
	logic signed [11:0] held_l;
	logic signed [11:0] held_r;

	// ---- sequencer ----
	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign fire     = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_MUL;
			ST_MUL:  state_d = ST_MIX;
			ST_MIX:  state_d = ST_DONE;
			ST_DONE: if (fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept)
			in_q <= in_word;
	end

	// ---- multiply stage ----
	assign gx    = q15_gain(in_q.knob_x);
	assign gy    = q15_gain(in_q.knob_y);
	assign src1  = in_q.cv_a_plugged ? {in_q.cv_in_a[11], in_q.cv_in_a} : {2'b0, lcg_q[31:21]};
	assign dec_m = dec_q - 3'd1;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			p1_s2 <= 29'($signed(src1)) * 29'($signed({1'b0, gx}));
			p2_s2 <= 28'(in_q.cv_in_b) * 28'($signed({1'b0, gy}));
			pp_s2 <= 31'(GAIN_UNITY - {1'b0, gy}) * 31'(CLK_SPAN);
			gy_s2 <= gy;
			r_s2  <= lcg_q[31:21];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q  <= LCG_FIRST;
			dec_q  <= DECIMATE;
			upd_s2 <= 1'b0;
		end else if (state_q == ST_MUL) begin
			// hold the word for the next tick, already advanced
			lcg_q  <= lcg_q * LCG_MUL + LCG_INC;
			dec_q  <= (dec_m == 3'd0) ? DECIMATE : dec_m;
			upd_s2 <= dec_m == 3'd0;
		end
	end

	// ---- mix stage ----
	always_comb begin
		s1       = p1_s2[27:15];
		gy_off   = $signed({1'b0, gy_s2}) - $signed(GAIN_HALF);
		s2       = in_q.cv_b_plugged ? p2_s2[27:15] : {gy_off[15], gy_off[15:4]};
		m1       = 26'(s1) * 26'($signed({1'b0, KNOB_MAX - in_q.knob_main}));
		m2       = 26'(s2) * 26'($signed({1'b0, in_q.knob_main}));
		period   = 17'({KNOB_MAX - in_q.knob_y, 3'b000}) + {1'b0, pp_s2[30:15]} + CLK_BASE;
		cnt_next = clk_cnt_q + 16'd1;
		pulse    = {1'b0, cnt_next} > period;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MIX)
			msum_s3 <= 27'(m1) + 27'(m2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_cnt_q <= '0;
			pulse_s3  <= 1'b0;
		end else if (state_q == ST_MIX) begin
			clk_cnt_q <= pulse ? 16'd0 : cnt_next;
			pulse_s3  <= pulse;
		end
	end

	// ---- finish stage: gates and sample-and-hold ----
	always_comb begin
		mix   = msum_s3[23:12];
		beat  = mix > $signed({1'b0, r_s2});
		a_lvl = gate_a_q;
		a_tmr = gate_a_tmr_q;
		b_lvl = gate_b_q;
		b_tmr = gate_b_tmr_q;
		hold  = hold_q;
		if (pulse_s3) begin
			a_lvl = 1'b1;
			a_tmr = GATE_TICKS;
		end
		if (beat && (pulse_s3 || in_q.trig_rise)) begin
			b_lvl = 1'b1;
			b_tmr = GATE_TICKS;
		end
		if (in_q.trig_plugged) begin
			// a plugged trigger restarts the gate A timer without raising it
			if (in_q.trig_rise) begin
				hold  = mix;
				a_tmr = GATE_TICKS;
			end
		end else if (pulse_s3) begin
			hold = mix;
		end
		if (a_tmr != 8'd0) begin
			a_tmr = a_tmr - 8'd1;
			if (a_tmr == 8'd0)
				a_lvl = 1'b0;
		end
		if (b_tmr != 8'd0) begin
			b_tmr = b_tmr - 8'd1;
			if (b_tmr == 8'd0)
				b_lvl = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_a_q     <= 1'b0;
			gate_b_q     <= 1'b0;
			gate_a_tmr_q <= GATE_TICKS;
			gate_b_tmr_q <= 8'd0;
			hold_q       <= '0;
		end else if (fire) begin
			gate_a_q     <= a_lvl;
			gate_b_q     <= b_lvl;
			gate_a_tmr_q <= a_tmr;
			gate_b_tmr_q <= b_tmr;
			hold_q       <= hold;
		end
	end

	// ---- delay store ----
	always_comb begin
		dctl.mul_en = state_q == ST_MUL;
		dctl.upd_en = (state_q == ST_MIX) && upd_s2;
		dctl.fresh  = upd_s2;
		dctl.commit = fire && upd_s2;
	end

	rcd_delay u_delay (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (dctl),
		.knob_main (in_q.knob_main),
		.audio_l   (in_q.audio_in_l),
		.audio_r   (in_q.audio_in_r),
		.held_l    (held_l),
		.held_r    (held_r)
	);

	// ---- output register ----
	always_comb begin
		out_d.mix_cv       = mix;
		out_d.held_cv      = hold;
		out_d.gate_a       = a_lvl;
		out_d.gate_b       = b_lvl;
		out_d.audio_out_l  = held_l;
		out_d.audio_out_r  = held_r;
		out_d.audio_update = upd_s2;
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_q <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

// File: hw/rtl/rcd_check.sv
// ---------------------------------------------------------------------------
// rcd_check
// Port-level checks of the random CV, clock and delay block.
// ---------------------------------------------------------------------------
module rcd_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input rcd_pkg::in_word_t  in_word,
	input logic               out_valid,
	input logic               out_ready,
	input rcd_pkg::out_word_t out_word
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// a stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_word))
		else $error("input word changed while stalled");

	// one word in flight: no acceptance right after another
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a word is in flight");

	// a fresh output word appears only after an accepted input word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 4))
		else $error("output word without matching input word");

endmodule

bind random_cv_clock_and_delay rcd_check u_rcd_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

// File: dv/rcd_tick_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rcd_tick_checker
// Watches both channels of the random CV, clock and delay block. Every
// accepted input word advances a private copy of the block's state (LCG,
// clock divider, gates, sample-and-hold, smoothed knob and the two delay
// lines) and queues the output word it must produce. Every accepted output
// word is compared field by field with the oldest queued word.
// ---------------------------------------------------------------------------
module rcd_tick_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  rcd_pkg::in_word_t  in_word,
	input  logic               out_valid,
	input  logic               out_ready,
	input  rcd_pkg::out_word_t out_word,
	output int                 errors,
	output int                 outstanding,
	output int                 words_checked,
	output int                 clock_pulses,
	output int                 gate_b_fires,
	output int                 hold_updates,
	output int                 audio_refreshes
);
	import rcd_pkg::*;

	localparam int FULL_SCALE = 2048;

	// predicted block state
	logic [31:0] lcg_state;
	logic [15:0] tick_count;
	logic [7:0]  gate_a_left;
	logic [7:0]  gate_b_left;
	logic        gate_a_on;
	logic        gate_b_on;
	logic [11:0] held_mix;
	logic [2:0]  decim_left;
	logic [11:0] knob_avg;
	int unsigned wr_ptr;
	logic [11:0] left_line  [DELAY_DEPTH];
	logic [11:0] right_line [DELAY_DEPTH];
	logic [11:0] left_tap;
	logic [11:0] right_tap;

	out_word_t predicted_words [$];
	out_word_t want;
	int        mismatch_total = 0;
	int        checked_total  = 0;
	int        pulse_total    = 0;
	int        fire_total     = 0;
	int        hold_total     = 0;
	int        refresh_total  = 0;

	function automatic int knob_gain(input logic [11:0] knob);
		int unsigned g;
		g = (32'(knob) << 15) / GAIN_DIV;
		return (g > 32767) ? 32767 : int'(g);
	endfunction

	task automatic clear_state();
		lcg_state   = LCG_INIT;
		tick_count  = '0;
		gate_a_left = GATE_TICKS;
		gate_b_left = '0;
		gate_a_on   = 1'b0;
		gate_b_on   = 1'b0;
		held_mix    = '0;
		decim_left  = DECIMATE;
		knob_avg    = '0;
		wr_ptr      = 0;
		left_tap    = '0;
		right_tap   = '0;
		for (int i = 0; i < DELAY_DEPTH; i++) begin
			left_line[i]  = '0;
			right_line[i] = '0;
		end
	endtask

	task automatic advance_tick(input in_word_t w, output out_word_t o);
		int          gain_x, gain_y, rnd, src_a, src_b, mix, period;
		int unsigned acc, lag, rd_ptr;
		bit          pulse, refresh;
		pulse   = 1'b0;
		refresh = 1'b0;
		lcg_state = lcg_state * LCG_MUL + LCG_INC;
		rnd    = int'(lcg_state >> 21);
		gain_x = knob_gain(w.knob_x);
		gain_y = knob_gain(w.knob_y);

		// unplugged inputs fall back to random value and a knob-set offset
		src_a = w.cv_a_plugged ? (int'(w.cv_in_a) * gain_x) >>> 15 : (gain_x * rnd) >>> 15;
		src_b = w.cv_b_plugged ? (int'(w.cv_in_b) * gain_y) >>> 15
		                       : (FULL_SCALE * (gain_y - int'(GAIN_HALF))) >>> 15;
		mix = (src_a * (int'(KNOB_MAX) - int'(w.knob_main))
		     + src_b * int'(w.knob_main)) >>> 12;

		period = ((int'(KNOB_MAX) - int'(w.knob_y)) << 3)
		       + (((int'(GAIN_UNITY) - gain_y) * int'(CLK_SPAN)) >>> 15)
		       + int'(CLK_BASE);
		tick_count = tick_count + 16'd1;
		if (int'(tick_count) > period) begin
			tick_count  = '0;
			gate_a_on   = 1'b1;
			gate_a_left = GATE_TICKS;
			pulse       = 1'b1;
			pulse_total++;
		end

		if (mix > rnd && (pulse || w.trig_rise)) begin
			gate_b_on   = 1'b1;
			gate_b_left = GATE_TICKS;
			fire_total++;
		end

		// a plugged trigger owns the hold and restarts gate A's timer
		if (w.trig_plugged) begin
			if (w.trig_rise) begin
				held_mix    = 12'(mix);
				gate_a_left = GATE_TICKS;
				hold_total++;
			end
		end else if (pulse) begin
			held_mix = 12'(mix);
			hold_total++;
		end

		if (gate_a_left != 0) begin
			gate_a_left = gate_a_left - 8'd1;
			if (gate_a_left == 0)
				gate_a_on = 1'b0;
		end
		if (gate_b_left != 0) begin
			gate_b_left = gate_b_left - 8'd1;
			if (gate_b_left == 0)
				gate_b_on = 1'b0;
		end

		decim_left = decim_left - 3'd1;
		if (decim_left == 0) begin
			decim_left = DECIMATE;
			refresh    = 1'b1;
		end

		if (refresh) begin
			acc      = 32'(w.knob_main) * 32'(SMOOTH_NEW) + 32'(knob_avg) * 32'(SMOOTH_OLD);
			knob_avg = 12'(acc >> 15);
			lag      = (32'(knob_avg) * DELAY_DEPTH) >> 12;
			wr_ptr   = wr_ptr % DELAY_DEPTH;
			left_line[wr_ptr]  = w.audio_in_l;
			right_line[wr_ptr] = w.audio_in_r;
			rd_ptr    = (wr_ptr + DELAY_DEPTH - lag) % DELAY_DEPTH;
			left_tap  = left_line[rd_ptr];
			right_tap = right_line[rd_ptr];
			wr_ptr    = (wr_ptr + 1) % DELAY_DEPTH;
			refresh_total++;
		end

		o.mix_cv       = 12'(mix);
		o.held_cv      = held_mix;
		o.gate_a       = gate_a_on;
		o.gate_b       = gate_b_on;
		o.audio_out_l  = left_tap;
		o.audio_out_r  = right_tap;
		o.audio_update = refresh;
	endtask

	task automatic check_field(input string label, input logic [11:0] exp_v,
		input logic [11:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, label,
				$signed(exp_v), $signed(act_v));
			mismatch_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			predicted_words.delete();
		end else begin
			// check the outgoing word first so a stray one cannot hide behind a new push
			if (out_valid && out_ready) begin
				if (predicted_words.size() == 0) begin
					$display("%0t: unexpected output word %h", $time, out_word);
					mismatch_total++;
				end else begin
					want = predicted_words.pop_front();
					check_field("mix_cv",       want.mix_cv,       out_word.mix_cv);
					check_field("held_cv",      want.held_cv,      out_word.held_cv);
					check_field("gate_a",       12'(want.gate_a),  12'(out_word.gate_a));
					check_field("gate_b",       12'(want.gate_b),  12'(out_word.gate_b));
					check_field("audio_out_l",  want.audio_out_l,  out_word.audio_out_l);
					check_field("audio_out_r",  want.audio_out_r,  out_word.audio_out_r);
					check_field("audio_update", 12'(want.audio_update),
						12'(out_word.audio_update));
					checked_total++;
				end
			end
			if (in_valid && in_ready) begin
				advance_tick(in_word, want);
				predicted_words.push_back(want);
			end
		end
		errors          <= mismatch_total;
		outstanding     <= predicted_words.size();
		words_checked   <= checked_total;
		clock_pulses    <= pulse_total;
		gate_b_fires    <= fire_total;
		hold_updates    <= hold_total;
		audio_refreshes <= refresh_total;
	end

endmodule

// File: dv/tb_random_cv_clock_and_delay.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_random_cv_clock_and_delay
// Drives sample ticks into the random CV, clock and delay block: a directed
// set of extreme and trigger cases, then random ticks biased toward a fast
// clock divider and short delays, with random gaps on the input side and
// random stalls on the output side. Checking is done by rcd_tick_checker.
// ---------------------------------------------------------------------------
module tb_random_cv_clock_and_delay;
	import rcd_pkg::*;

	localparam int DIRECTED_TICKS = 20;
	localparam int RANDOM_TICKS   = 1500;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_word   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_word;

	int errors, outstanding, words_checked;
	int clock_pulses, gate_b_fires, hold_updates, audio_refreshes;
	int stall_left = 0;
	int sink_cycle = 0;

	always #1 clk = ~clk;

	random_cv_clock_and_delay DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	rcd_tick_checker tick_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_word         (in_word),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_word        (out_word),
		.errors          (errors),
		.outstanding     (outstanding),
		.words_checked   (words_checked),
		.clock_pulses    (clock_pulses),
		.gate_b_fires    (gate_b_fires),
		.hold_updates    (hold_updates),
		.audio_refreshes (audio_refreshes)
	);

	// receiver: mostly ready, short stalls, now and then a long one
	always @(posedge clk) begin
		sink_cycle <= sink_cycle + 1;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ((sink_cycle / 400) % 3 == 2 || $urandom_range(0, 99) < 70) begin
			out_ready <= 1'b1;
		end else begin
			out_ready  <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
			                                          : $urandom_range(0, 2);
		end
	end

	function automatic int pick_gap(input int n);
		int roll;
		roll = $urandom_range(0, 99);
		if ((n / 128) % 4 == 1)
			return 0;
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// fast clock most of the time so gates and holds fire often;
	// alternate short and full-range delays
	function automatic in_word_t random_tick(input int n);
		in_word_t w;
		w.knob_main    = ((n / 256) % 2 == 0) ? 12'($urandom_range(0, 96)) : 12'($urandom);
		w.knob_x       = ($urandom_range(0, 7) == 0) ? KNOB_MAX : 12'($urandom);
		w.knob_y       = ($urandom_range(0, 4) != 0) ? 12'($urandom_range(4032, 4095))
		                                             : 12'($urandom);
		w.cv_in_a      = 12'($urandom);
		w.cv_in_b      = 12'($urandom);
		w.cv_a_plugged = 1'($urandom);
		w.cv_b_plugged = 1'($urandom);
		w.trig_plugged = 1'($urandom);
		w.trig_rise    = ($urandom_range(0, 6) == 0);
		w.audio_in_l   = 12'($urandom);
		w.audio_in_r   = 12'($urandom);
		return w;
	endfunction

	function automatic in_word_t directed_tick(input int k);
		in_word_t w;
		w = random_tick(0);
		case (k)
			0: w = '0;
			1: begin
				w           = '1;
				w.cv_in_a   = 12'h7ff;
				w.cv_in_b   = 12'h7ff;
				w.audio_in_l = 12'h7ff;
				w.audio_in_r = 12'h7ff;
			end
			2: begin
				w            = '0;
				w.knob_main  = KNOB_MAX;
				w.knob_x     = KNOB_MAX;
				w.knob_y     = KNOB_MAX;
				w.cv_in_a    = 12'h800;
				w.cv_in_b    = 12'h800;
				w.audio_in_l = 12'h800;
				w.audio_in_r = 12'h800;
				w.cv_a_plugged = 1'b1;
				w.cv_b_plugged = 1'b1;
			end
			3: begin
				// random source at saturated gain, knob-set offset at minimum
				w.knob_main    = '0;
				w.knob_x       = KNOB_MAX;
				w.knob_y       = '0;
				w.cv_a_plugged = 1'b0;
				w.cv_b_plugged = 1'b0;
			end
			4: begin
				w.knob_main    = KNOB_MAX;
				w.knob_x       = '0;
				w.knob_y       = KNOB_MAX;
				w.cv_a_plugged = 1'b0;
				w.cv_b_plugged = 1'b0;
			end
			5: begin
				// edge on an unplugged trigger input
				w.trig_plugged = 1'b0;
				w.trig_rise    = 1'b1;
			end
			6, 7: begin
				w.knob_main    = '0;
				w.knob_x       = KNOB_MAX;
				w.cv_a_plugged = 1'b1;
				w.cv_in_a      = (k == 6) ? 12'h7ff : 12'h800;
				w.trig_plugged = 1'b1;
				w.trig_rise    = 1'b1;
			end
			8: begin
				w.trig_plugged = 1'b1;
				w.trig_rise    = 1'b0;
			end
			default: begin
				w.knob_y    = KNOB_MAX;
				w.knob_main = k[0] ? KNOB_MAX : '0;
				w.knob_x    = k[1] ? KNOB_MAX : '0;
				w.trig_rise = k[2];
			end
		endcase
		return w;
	endfunction

	task automatic send_tick(input in_word_t w, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIRECTED_TICKS; k++)
			send_tick(directed_tick(k), pick_gap(k));
		for (int n = 0; n < RANDOM_TICKS; n++)
			send_tick(random_tick(n), pick_gap(n));
		in_valid <= 1'b0;

		// let the count include the last accepted word before draining
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Checked %0d output words over %0d sample ticks.", words_checked,
			DIRECTED_TICKS + RANDOM_TICKS);
		$display("Saw %0d clock pulses, %0d random gate firings, %0d CV holds, %0d delay reads.",
			clock_pulses, gate_b_fires, hold_updates, audio_refreshes);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
